@@ hw/rtl/bcva_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Block code vote accumulator package
// Sizes, command codes, sequencer states and the structs passed between the
// vote accumulator modules.
// ----------------------------------------------------------------------------
package bcva_pkg;

   localparam int NUM_BLOCKS  = 32;
   localparam int BLOCK_SIZE  = 32;
   localparam int COUNT_BITS  = 16;

   localparam int DEPTH       = NUM_BLOCKS * BLOCK_SIZE;
   localparam int ADDR_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int POS_W       = (BLOCK_SIZE > 1) ? $clog2(BLOCK_SIZE) : 1;
   localparam int MAX_READOUT = 32;
   localparam int READ_BLOCKS = (NUM_BLOCKS < MAX_READOUT) ? NUM_BLOCKS : MAX_READOUT;
   localparam int WALK_BLK_W  = (READ_BLOCKS > 1) ? $clog2(READ_BLOCKS) : 1;

   localparam int CMD_W       = 2;
   localparam int BLK_W       = 5;
   localparam int IDX_W       = 5;
   localparam int WEIGHT_W    = 16;
   localparam int VOTES_W     = 16;
   localparam int TOTAL_W     = 32;

   typedef enum logic [CMD_W-1:0] {
      CMD_ADD   = 2'd0,
      CMD_CLEAR = 2'd1,
      CMD_READ  = 2'd2
   } cmd_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ
   } state_type;

   typedef struct packed {
      logic                  first;
      logic                  last;
      logic                  final_blk;
      logic [WALK_BLK_W-1:0] blk;
      logic [POS_W-1:0]      pos;
   } walk_tag_type;

   typedef struct packed {
      logic                valid;
      logic [BLK_W-1:0]    blk;
      logic [IDX_W-1:0]    idx;
      logic [VOTES_W-1:0]  votes;
      logic                run_end;
   } vote_result_type;

endpackage
`default_nettype wire

@@ hw/rtl/bcva_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Vote counter memory
// Simple dual-port synchronous RAM with one write port and one registered
// read port; a read of the address being written returns the old data.
// ----------------------------------------------------------------------------
module bcva_ram #(
   parameter int DEPTH  = 1024,
   parameter int WIDTH  = 16,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic                  clock,
   input  wire logic                  wr_en,
   input  wire logic [ADDR_W-1:0]     wr_addr,
   input  wire logic [WIDTH-1:0]      wr_data,
   input  wire logic                  rd_en,
   input  wire logic [ADDR_W-1:0]     rd_addr,
   output      logic [WIDTH-1:0]      rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

@@ hw/rtl/bcva_argmax.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Vote argmax unit
// Scans the counters of one block as they stream out of the memory and
// keeps the largest value and its position, the lowest position on ties.
// ----------------------------------------------------------------------------
module bcva_argmax
   import bcva_pkg::*;
(
   input  wire logic                         clock,
   input  wire logic                         consume,
   input  wire walk_tag_type                 tag,
   input  wire logic signed [COUNT_BITS-1:0] data,
   output      vote_result_type              result
);

   logic signed [COUNT_BITS-1:0] best_ff;
   logic signed [COUNT_BITS-1:0] best_in;
   logic [POS_W-1:0]             best_pos_ff;
   logic [POS_W-1:0]             best_pos_in;
   logic                         take;

   always_comb begin
      take        = tag.first || (data > best_ff);
      best_in     = take ? data : best_ff;
      best_pos_in = take ? tag.pos : best_pos_ff;
   end

   always_ff @(posedge clock) begin
      if (consume) begin
         best_ff     <= best_in;
         best_pos_ff <= best_pos_in;
      end
   end

   always_comb begin
      result.valid   = consume && tag.last;
      result.blk     = BLK_W'(tag.blk);
      result.idx     = IDX_W'(best_pos_in);
      result.votes   = VOTES_W'(best_in);
      result.run_end = tag.final_blk;
   end

endmodule
`default_nettype wire

@@ hw/rtl/block_code_vote_accumulator.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Block code vote accumulator
// Table of signed vote counters for a block-sparse code with add, clear and
// binarise commands.
// ----------------------------------------------------------------------------
// Usage: words enter on the req_ channel and readout words leave on the rsp_
// channel; a word moves when valid is high and stall is low.
// While idle, an add word is taken every cycle and makes no output word;
// its counter is read on acceptance, the sum is written back from the add
// stage; write-back forwarding covers back-to-back adds to one counter.
// A clear word sweeps all 1024 entries of the counter memory, one per cycle,
// while req_stall is high. The same sweep runs after reset.
// A binarise word walks all 1024 counters through the single memory read
// port, one per cycle while the output is not stalled, and emits one word
// per block, in block order, the last with rsp_run_end set.
// Clear and binarise wait until a pending add has been written back.
// While a valid output word is stalled the walk pauses and the word stays held.
// Reset is synchronous and active high and starts the clearing sweep.
// ----------------------------------------------------------------------------
module block_code_vote_accumulator
   import bcva_pkg::*;
(
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output      logic                       req_stall,
   input  wire logic [CMD_W-1:0]           req_cmd,
   input  wire logic [BLK_W-1:0]           req_block_num,
   input  wire logic [IDX_W-1:0]           req_active_index,
   input  wire logic signed [WEIGHT_W-1:0] req_vote_weight,
   input  wire logic                       req_vector_end,
   output      logic                       rsp_valid,
   input  wire logic                       rsp_stall,
   output      logic [BLK_W-1:0]           rsp_out_block,
   output      logic [IDX_W-1:0]           rsp_winner_index,
   output      logic signed [VOTES_W-1:0]  rsp_winner_votes,
   output      logic [TOTAL_W-1:0]         rsp_contributor_total,
   output      logic                       rsp_run_end
);

   state_type state_ff, state_in;

   logic req_accept;
   logic is_add, is_clear, is_read;
   logic in_range;
   logic [ADDR_W-1:0] add_addr;

   logic [ADDR_W-1:0] clr_addr_ff, clr_addr_in;

   logic                  s1_valid_ff, s1_valid_in;
   logic [ADDR_W-1:0]     s1_addr_ff;
   logic [COUNT_BITS-1:0] s1_weight_ff;
   logic                  wb_valid_ff, wb_valid_in;
   logic [ADDR_W-1:0]     wb_addr_ff;
   logic [COUNT_BITS-1:0] wb_data_ff;
   logic [COUNT_BITS-1:0] old_count;
   logic [COUNT_BITS-1:0] new_count;

   logic [TOTAL_W-1:0] vec_count_ff, vec_count_in;

   logic                  advance;
   logic                  issue;
   logic                  consume;
   logic                  walk_start;
   logic                  walk_pos_last;
   logic                  walk_blk_last;
   logic [POS_W-1:0]      walk_pos_ff, walk_pos_in;
   logic [WALK_BLK_W-1:0] walk_blk_ff, walk_blk_in;
   logic [ADDR_W-1:0]     walk_addr_ff, walk_addr_in;
   logic                  issue_done_ff, issue_done_in;
   logic                  rd_valid_ff, rd_valid_in;
   walk_tag_type          rd_tag_ff, rd_tag_in;

   logic                  mem_wr_en;
   logic [ADDR_W-1:0]     mem_wr_addr;
   logic [COUNT_BITS-1:0] mem_wr_data;
   logic                  mem_rd_en;
   logic [ADDR_W-1:0]     mem_rd_addr;
   logic [COUNT_BITS-1:0] mem_rd_data;

   vote_result_type vote_res;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [BLK_W-1:0]    rsp_out_block_ff;
   logic [IDX_W-1:0]    rsp_winner_index_ff;
   logic [VOTES_W-1:0]  rsp_winner_votes_ff;
   logic [TOTAL_W-1:0]  rsp_contributor_total_ff;
   logic                rsp_run_end_ff;

   // Command decode.
   always_comb begin
      is_add     = req_cmd == CMD_ADD;
      is_clear   = req_cmd == CMD_CLEAR;
      is_read    = req_cmd == CMD_READ;
      req_accept = req_valid && !req_stall;
      in_range   = (32'(req_block_num) < NUM_BLOCKS) && (32'(req_active_index) < BLOCK_SIZE);
      add_addr   = ADDR_W'(32'(req_block_num) * BLOCK_SIZE + 32'(req_active_index));
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_addr_ff == ADDR_W'(DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_accept && is_clear) begin
               state_in = ST_CLEAR;
            end else if (req_accept && is_read) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            if (consume && rd_tag_ff.last && rd_tag_ff.final_blk) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Sequencer outputs.
   always_comb begin
      case (state_ff)
         ST_IDLE: begin
            req_stall = s1_valid_ff && (is_clear || is_read);
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   always_comb begin
      clr_addr_in = '0;
      if (state_ff == ST_CLEAR && clr_addr_ff != ADDR_W'(DEPTH - 1)) begin
         clr_addr_in = clr_addr_ff + 1'b1;
      end
   end

   // Add pipeline with write-back forwarding.
   always_comb begin
      s1_valid_in = req_accept && is_add && in_range;
      wb_valid_in = s1_valid_ff;
      old_count   = (wb_valid_ff && wb_addr_ff == s1_addr_ff) ? wb_data_ff : mem_rd_data;
      new_count   = old_count + s1_weight_ff;
   end

   always_comb begin
      vec_count_in = vec_count_ff;
      if (req_accept && is_add && req_vector_end && vec_count_ff != '1) begin
         vec_count_in = vec_count_ff + 1'b1;
      end else if (req_accept && is_clear) begin
         vec_count_in = '0;
      end
   end

   // Readout walk.
   always_comb begin
      advance       = !(rsp_valid_ff && rsp_stall);
      walk_start    = req_accept && is_read;
      issue         = (state_ff == ST_READ) && advance && !issue_done_ff;
      consume       = (state_ff == ST_READ) && rd_valid_ff && advance;
      walk_pos_last = walk_pos_ff == POS_W'(BLOCK_SIZE - 1);
      walk_blk_last = walk_blk_ff == WALK_BLK_W'(READ_BLOCKS - 1);

      walk_pos_in   = walk_pos_ff;
      walk_blk_in   = walk_blk_ff;
      walk_addr_in  = walk_addr_ff;
      issue_done_in = issue_done_ff;
      if (walk_start) begin
         walk_pos_in   = '0;
         walk_blk_in   = '0;
         walk_addr_in  = '0;
         issue_done_in = 1'b0;
      end else if (issue) begin
         walk_addr_in = walk_addr_ff + 1'b1;
         if (walk_pos_last) begin
            walk_pos_in = '0;
            walk_blk_in = walk_blk_ff + 1'b1;
            if (walk_blk_last) begin
               issue_done_in = 1'b1;
            end
         end else begin
            walk_pos_in = walk_pos_ff + 1'b1;
         end
      end

      rd_tag_in.first     = walk_pos_ff == '0;
      rd_tag_in.last      = walk_pos_last;
      rd_tag_in.final_blk = walk_blk_last;
      rd_tag_in.blk       = walk_blk_ff;
      rd_tag_in.pos       = walk_pos_ff;

      rd_valid_in = 1'b0;
      if (state_ff == ST_READ) begin
         rd_valid_in = advance ? issue : rd_valid_ff;
      end
   end

   // Memory port selection.
   always_comb begin
      mem_rd_en   = issue || s1_valid_in;
      mem_rd_addr = issue ? walk_addr_ff : add_addr;
      mem_wr_en   = s1_valid_ff || (state_ff == ST_CLEAR);
      mem_wr_addr = s1_valid_ff ? s1_addr_ff : clr_addr_ff;
      mem_wr_data = s1_valid_ff ? new_count : '0;
   end

   always_comb begin
      rsp_valid_in = vote_res.valid || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_addr_ff   <= '0;
         s1_valid_ff   <= 1'b0;
         wb_valid_ff   <= 1'b0;
         vec_count_ff  <= '0;
         issue_done_ff <= 1'b1;
         rd_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_addr_ff   <= clr_addr_in;
         s1_valid_ff   <= s1_valid_in;
         wb_valid_ff   <= wb_valid_in;
         vec_count_ff  <= vec_count_in;
         issue_done_ff <= issue_done_in;
         rd_valid_ff   <= rd_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      walk_pos_ff  <= walk_pos_in;
      walk_blk_ff  <= walk_blk_in;
      walk_addr_ff <= walk_addr_in;
      if (s1_valid_in) begin
         s1_addr_ff   <= add_addr;
         s1_weight_ff <= COUNT_BITS'(req_vote_weight);
      end
      if (s1_valid_ff) begin
         wb_addr_ff <= s1_addr_ff;
         wb_data_ff <= new_count;
      end
      if (issue) begin
         rd_tag_ff <= rd_tag_in;
      end
      if (vote_res.valid) begin
         rsp_out_block_ff         <= vote_res.blk;
         rsp_winner_index_ff      <= vote_res.idx;
         rsp_winner_votes_ff      <= vote_res.votes;
         rsp_contributor_total_ff <= vec_count_ff;
         rsp_run_end_ff           <= vote_res.run_end;
      end
   end

   bcva_ram #(
      .DEPTH (DEPTH),
      .WIDTH (COUNT_BITS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   bcva_argmax u_argmax (
      .clock   (clock),
      .consume (consume),
      .tag     (rd_tag_ff),
      .data    ($signed(mem_rd_data)),
      .result  (vote_res)
   );

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_out_block         = rsp_out_block_ff;
   assign rsp_winner_index      = rsp_winner_index_ff;
   assign rsp_winner_votes      = $signed(rsp_winner_votes_ff);
   assign rsp_contributor_total = rsp_contributor_total_ff;
   assign rsp_run_end           = rsp_run_end_ff;

   // The clearing sweep owns the write port alone.
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CLEAR |-> !s1_valid_ff && !rd_valid_ff)
      else $error("add or readout in flight during clearing sweep");

   // A finished block never overwrites a held output word.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_stall |-> !vote_res.valid)
      else $error("readout word produced while output is stalled");

   // The final word of a readout belongs to the last block read out.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_run_end_ff |-> rsp_out_block_ff == BLK_W'(READ_BLOCKS - 1))
      else $error("run end flagged on wrong block");

   // Forwarding is only armed by a write-back in the previous cycle.
   assert property (@(posedge clock) disable iff (reset)
      wb_valid_ff |-> $past(s1_valid_ff))
      else $error("forwarding register valid without write-back");

endmodule
`default_nettype wire

@@ dv/tb_block_code_vote_accumulator.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Block code vote accumulator testbench
// Sends add, clear, binarise and unused command words through the req_
// channel with random idle gaps. It keeps its own table of vote counters and
// a contributor count, and forms the readout words that each binarise word
// must produce. Each readout word is checked field by field, in order.
// Directed words cover counter wrap, ties and ignored commands. Random add
// episodes, some with negative winners, mostly end in readouts. The receiver
// stalls at random, and once holds off so long that the block stalls its input.
// ----------------------------------------------------------------------------
module tb_block_code_vote_accumulator
   import bcva_pkg::*;
;

   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
   localparam int CYCLE_LIMIT   = 3_000_000;
   localparam int HOLD_CYCLES   = 1500;
   localparam int HOLD_AT_READ  = 3;
   localparam int DRAIN_CYCLES  = 1100;
   localparam int RANDOM_WORDS  = 365;

   typedef struct {
      logic [CMD_W-1:0]           cmd;
      logic [BLK_W-1:0]           blk;
      logic [IDX_W-1:0]           idx;
      logic signed [WEIGHT_W-1:0] weight;
      logic                       vend;
   } vote_word_type;

   typedef struct {
      logic [BLK_W-1:0]          blk;
      logic [IDX_W-1:0]          idx;
      logic signed [VOTES_W-1:0] votes;
      logic [TOTAL_W-1:0]        total;
      logic                      last;
   } readout_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                       req_valid        = 1'b0;
   logic                       req_stall;
   logic [CMD_W-1:0]           req_cmd          = '0;
   logic [BLK_W-1:0]           req_block_num    = '0;
   logic [IDX_W-1:0]           req_active_index = '0;
   logic signed [WEIGHT_W-1:0] req_vote_weight  = '0;
   logic                       req_vector_end   = 1'b0;
   logic                       rsp_valid;
   logic                       rsp_stall        = 1'b0;
   logic [BLK_W-1:0]           rsp_out_block;
   logic [IDX_W-1:0]           rsp_winner_index;
   logic signed [VOTES_W-1:0]  rsp_winner_votes;
   logic [TOTAL_W-1:0]         rsp_contributor_total;
   logic                       rsp_run_end;

   vote_word_type word_queue[$];
   readout_type   readout_due[$];

   logic signed [COUNT_BITS-1:0] vote_table [NUM_BLOCKS][BLOCK_SIZE];
   logic [TOTAL_W-1:0]           vector_tally;

   bit req_taken = 1'b0;
   bit rsp_taken = 1'b0;
   bit req_calm  = 1'b0;
   bit rsp_calm  = 1'b0;
   int req_gap   = 0;
   int rsp_gap   = 0;
   int reads_seen = 0;
   int hold_left  = 0;
   bit hold_done  = 1'b0;
   int cycle_count = 0;
   int failures    = 0;

   block_code_vote_accumulator dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_cmd              (req_cmd),
      .req_block_num        (req_block_num),
      .req_active_index     (req_active_index),
      .req_vote_weight      (req_vote_weight),
      .req_vector_end       (req_vector_end),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_out_block        (rsp_out_block),
      .rsp_winner_index     (rsp_winner_index),
      .rsp_winner_votes     (rsp_winner_votes),
      .rsp_contributor_total(rsp_contributor_total),
      .rsp_run_end          (rsp_run_end)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic void zero_tally();
      for (int b = 0; b < NUM_BLOCKS; b++)
         for (int i = 0; i < BLOCK_SIZE; i++)
            vote_table[b][i] = '0;
      vector_tally = '0;
   endfunction

   function automatic void tally_word(input vote_word_type w);
      readout_type               r;
      int                        best;
      logic signed [VOTES_W-1:0] best_votes;
      case (w.cmd)
         CMD_ADD: begin
            vote_table[w.blk][w.idx] = vote_table[w.blk][w.idx] + w.weight;
            if (w.vend && vector_tally != '1)
               vector_tally = vector_tally + 1;
         end
         CMD_CLEAR: begin
            zero_tally();
         end
         CMD_READ: begin
            for (int b = 0; b < READ_BLOCKS; b++) begin
               best = 0;
               best_votes = vote_table[b][0];
               for (int i = 1; i < BLOCK_SIZE; i++) begin
                  if (vote_table[b][i] > best_votes) begin
                     best = i;
                     best_votes = vote_table[b][i];
                  end
               end
               r.blk   = BLK_W'(b);
               r.idx   = IDX_W'(best);
               r.votes = best_votes;
               r.total = vector_tally;
               r.last  = (b == READ_BLOCKS - 1);
               readout_due.push_back(r);
            end
         end
         default: ;
      endcase
   endfunction

   function automatic void queue_word(input logic [CMD_W-1:0] cmd, input int blk,
                                      input int idx, input int weight, input bit vend);
      vote_word_type w;
      w.cmd    = cmd;
      w.blk    = BLK_W'(blk);
      w.idx    = IDX_W'(idx);
      w.weight = WEIGHT_W'(weight);
      w.vend   = vend;
      word_queue.push_back(w);
   endfunction

   function automatic void compare_field(input string fname, input logic signed [63:0] want,
                                         input logic signed [63:0] got);
      if (want !== got) begin
         $error("%s: expected %0d, got %0d", fname, want, got);
         failures++;
      end
   endfunction

   // Sender: a new word goes out only once the previous one has been taken.
   always @(negedge clock) begin
      vote_word_type w;
      if (!req_valid || req_taken) begin
         if (req_taken) begin
            if ($urandom_range(0, 39) == 0)
               req_calm = !req_calm;
            req_gap = req_calm ? 0 : $urandom_range(0, 6);
         end
         if (req_gap > 0) begin
            req_gap--;
            req_valid <= 1'b0;
         end else if (word_queue.size() > 0) begin
            w = word_queue.pop_front();
            req_cmd          <= w.cmd;
            req_block_num    <= w.blk;
            req_active_index <= w.idx;
            req_vote_weight  <= w.weight;
            req_vector_end   <= w.vend;
            req_valid        <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (rsp_taken) begin
         if ($urandom_range(0, 39) == 0)
            rsp_calm = !rsp_calm;
         rsp_gap = rsp_calm ? 0 : $urandom_range(0, 6);
      end
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
      end else if (rsp_valid && rsp_gap > 0) begin
         rsp_gap--;
         rsp_stall <= 1'b1;
      end else if (!rsp_valid) begin
         rsp_stall <= ($urandom_range(0, 3) == 0);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // The long hold-off starts once three readouts have been requested.
   always @(posedge clock) begin
      if (!hold_done && reads_seen == HOLD_AT_READ) begin
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
      end
   end

   always @(posedge clock) begin
      vote_word_type w;
      readout_type   want;
      req_taken = !reset && req_valid && !req_stall;
      rsp_taken = !reset && rsp_valid && !rsp_stall;
      if (req_taken) begin
         w.cmd    = req_cmd;
         w.blk    = req_block_num;
         w.idx    = req_active_index;
         w.weight = req_vote_weight;
         w.vend   = req_vector_end;
         tally_word(w);
         if (w.cmd == CMD_READ)
            reads_seen <= reads_seen + 1;
      end
      if (rsp_taken) begin
         if (readout_due.size() == 0) begin
            $error("readout word for block %0d arrived with none expected", rsp_out_block);
            failures++;
         end else begin
            want = readout_due.pop_front();
            compare_field("out_block", want.blk, rsp_out_block);
            compare_field("winner_index", want.idx, rsp_winner_index);
            compare_field("winner_votes", want.votes, rsp_winner_votes);
            compare_field("contributor_total", want.total, rsp_contributor_total);
            compare_field("run_end", want.last, rsp_run_end);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("[block_code_vote_accumulator] ERROR");
         $finish;
      end
   end

   initial begin
      int counted;
      int hot_a;
      int hot_b;
      int blk;
      int idx;
      int weight;
      int n;
      zero_tally();
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      queue_word(CMD_READ, 0, 0, 0, 1'b0);
      queue_word(CMD_ADD, 0, 0, 32767, 1'b1);
      queue_word(CMD_ADD, 0, 0, 1, 1'b0);
      queue_word(CMD_ADD, 31, 31, -32768, 1'b1);
      queue_word(CMD_ADD, 31, 31, -1, 1'b0);
      queue_word(CMD_ADD, 5, 7, 100, 1'b0);
      queue_word(CMD_ADD, 5, 3, 100, 1'b0);
      queue_word(CMD_ADD, 5, 31, 100, 1'b1);
      queue_word(CMD_ADD, 9, 2, -5, 1'b0);
      queue_word(CMD_UNUSED, 31, 31, -1, 1'b1);
      queue_word(CMD_READ, 31, 31, -1, 1'b1);
      queue_word(CMD_CLEAR, 31, 31, -1, 1'b1);
      queue_word(CMD_READ, 0, 0, 0, 1'b0);
      queue_word(CMD_ADD, 17, 21, 'h5555, 1'b1);
      queue_word(CMD_ADD, 10, 10, 'h2AAA, 1'b0);
      queue_word(CMD_READ, 10, 21, 'h5555, 1'b0);

      counted = 0;
      while (counted < RANDOM_WORDS) begin
         if ($urandom_range(0, 2) == 0) begin
            queue_word(CMD_CLEAR, $urandom, $urandom, $urandom, $urandom_range(0, 1) != 0);
            counted++;
         end
         hot_a = $urandom_range(0, 31);
         hot_b = $urandom_range(0, 31);
         blk = hot_a;
         idx = 0;
         if ($urandom_range(0, 5) == 0) begin
            // Every position of one block gets a negative vote.
            for (int i = 0; i < BLOCK_SIZE; i++)
               queue_word(CMD_ADD, hot_a, i, -int'($urandom_range(1, 4000)),
                          $urandom_range(0, 1) != 0);
            counted += BLOCK_SIZE;
         end
         n = $urandom_range(3, 30);
         for (int k = 0; k < n; k++) begin
            if (k == 0 || $urandom_range(0, 5) != 0) begin
               case ($urandom_range(0, 3))
                  0:       blk = $urandom_range(0, 31);
                  1:       blk = hot_b;
                  default: blk = hot_a;
               endcase
               idx = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 31) : $urandom_range(0, 3);
            end
            case ($urandom_range(0, 3))
               0:       weight = int'($urandom_range(0, 16)) - 8;
               1:       weight = $urandom;
               2:       weight = $urandom_range(0, 1) ? 32767 : -32768;
               default: weight = 1;
            endcase
            queue_word(CMD_ADD, blk, idx, weight, $urandom_range(0, 2) == 0);
            counted++;
            if ($urandom_range(0, 19) == 0)
               queue_word(CMD_UNUSED, $urandom, $urandom, $urandom,
                          $urandom_range(0, 1) != 0);
         end
         if ($urandom_range(0, 4) != 0) begin
            queue_word(CMD_READ, $urandom, $urandom, $urandom, $urandom_range(0, 1) != 0);
            counted++;
         end
      end

      while (word_queue.size() > 0 || req_valid)
         @(posedge clock);
      while (readout_due.size() > 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (failures == 0)
         $display("[block_code_vote_accumulator] OK");
      else
         $display("[block_code_vote_accumulator] ERROR");
      $finish;
   end

endmodule
`default_nettype wire
